### sv/mprc_pkg.sv
package mprc_pkg;

	// Block sizing
	localparam int THREADS     = 4;
	localparam int PC_BITS     = 32;
	localparam int STACK_DEPTH = 16;

	// PCs arrive on 32-bit ports, so at most 32 bits are ever significant
	localparam int PC_W  = (PC_BITS < 32) ? PC_BITS : 32;
	localparam int TID_W = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int TOP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	typedef logic [THREADS-1:0] tmask_t;
	typedef logic [PC_W-1:0]    pc_t;
	typedef logic [TID_W-1:0]   tid_t;
	typedef logic [TOP_W-1:0]   top_t;

	localparam tmask_t TMASK_ALL = '1;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_NONE       = 2'd1,
		STATUS_BAD_RETURN = 2'd2,
		STATUS_OVERFLOW   = 2'd3
	} status_t;

	// Per-thread view of the top frame and previous beat
	typedef struct packed {
		logic ign;
		logic fun;
		logic cur;
		logic prev_act;
		logic pending;
	} lane_ctl_t;

	// What one lane found
	typedef struct packed {
		logic cur_chk;   // current bit after the backward-branch check
		logic elig_a;    // eligible with current as it stands
		logic elig_b;    // eligible once current is refilled
		logic act;       // eligible and at the reference PC
	} lane_t;

	// Result of the merging stage
	typedef struct packed {
		logic found;
		logic refill;
		tid_t ref_id;
		pc_t  ref_pc;
	} pick_t;

	// Frame update request
	typedef struct packed {
		logic   fire;
		logic   found;
		logic   call;
		logic   ret;
		tmask_t active;
		tmask_t cur;
	} stack_cmd_t;

	typedef struct packed {
		logic overflow;
		logic bad_return;
	} stack_flags_t;

endpackage

### sv/min_pc_thread_reconvergence_core.sv
// Min-PC reconvergence scheduler: each input beat carries every thread's next PC and its
// ignore, branch, call and return masks; the block answers with one result beat giving the
// active threads, the reference thread, their shared PC and a status code. One item is taken
// per clock while input stall is low: the four lanes, the minimum-PC merge and the frame-stack
// update settle combinationally, because the next item needs the stack top this one leaves. The
// result is registered; a skid register lets one more item in while a result is held, and input
// stall rises only when both are occupied. Reset is immediate, with no clearing pass.
module min_pc_thread_reconvergence_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] pc_thread_zero,
	input  logic [31:0] pc_thread_one,
	input  logic [31:0] pc_thread_two,
	input  logic [31:0] pc_thread_three,
	input  logic [3:0]  ignore_mask,
	input  logic [3:0]  branch_mask,
	input  logic [3:0]  call_mask,
	input  logic [3:0]  return_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  active_mask,
	output logic [1:0]  chosen_thread,
	output logic [31:0] chosen_pc,
	output logic [1:0]  status
);
	import mprc_pkg::*;

	typedef struct packed {
		logic [3:0]  active;
		logic [1:0]  chosen;
		logic [31:0] pc;
		logic [1:0]  code;
	} res_t;

	logic [31:0]  pc_raw [4];
	pc_t          pc [THREADS];
	pc_t          last_pc_q [THREADS];
	tmask_t       prev_act_q;
	logic         pending_q;

	tmask_t       ign, brm, cam, rem;
	tmask_t       top_cur, top_fun;
	tmask_t       cur_chk, elig_a, elig_b, act;
	lane_t        lane_res [THREADS];
	pick_t        pick;
	stack_cmd_t   cmd;
	stack_flags_t flags;

	logic         in_fire, out_fire;
	res_t         res_d, out_q, skid_q;
	logic         out_valid_q, skid_valid_q;

	assign in_fire  = in_valid & ~in_stall;
	assign out_fire = out_valid_q & ~out_stall;
	assign in_stall = skid_valid_q;

	assign pc_raw[0] = pc_thread_zero;
	assign pc_raw[1] = pc_thread_one;
	assign pc_raw[2] = pc_thread_two;
	assign pc_raw[3] = pc_thread_three;

	assign ign = ignore_mask[THREADS-1:0];
	assign brm = branch_mask[THREADS-1:0];
	assign cam = call_mask[THREADS-1:0];
	assign rem = return_mask[THREADS-1:0];

	// One lane per thread
	for (genvar g = 0; g < THREADS; g++) begin : g_lane
		lane_ctl_t ctl;

		assign pc[g]        = pc_raw[g][PC_W-1:0];
		assign ctl.ign      = ign[g];
		assign ctl.fun      = top_fun[g];
		assign ctl.cur      = top_cur[g];
		assign ctl.prev_act = prev_act_q[g];
		assign ctl.pending  = pending_q;

		mprc_lane u_lane (
			.pc      (pc[g]),
			.last_pc (last_pc_q[g]),
			.ref_pc  (pick.ref_pc),
			.ctl     (ctl),
			.res     (lane_res[g])
		);

		assign cur_chk[g] = lane_res[g].cur_chk;
		assign elig_a[g]  = lane_res[g].elig_a;
		assign elig_b[g]  = lane_res[g].elig_b;
		assign act[g]     = lane_res[g].act;
	end

	// Merge: reference thread and PC
	mprc_merge u_merge (
		.pc     (pc),
		.elig_a (elig_a),
		.elig_b (elig_b),
		.pick   (pick)
	);

	// Frame stack request
	assign cmd.fire   = in_fire;
	assign cmd.found  = pick.found;
	assign cmd.call   = cam[pick.ref_id];
	assign cmd.ret    = rem[pick.ref_id];
	assign cmd.active = act;
	assign cmd.cur    = (pick.refill ? TMASK_ALL : cur_chk) | act;

	mprc_stack u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.top_cur (top_cur),
		.top_fun (top_fun),
		.flags   (flags)
	);

	// Result of this beat
	always_comb begin
		res_d.active = 4'(act);
		res_d.chosen = 2'(pick.ref_id);
		res_d.pc     = 32'(pick.ref_pc);
		if (!pick.found)
			res_d.code = STATUS_NONE;
		else if (flags.overflow)
			res_d.code = STATUS_OVERFLOW;
		else if (flags.bad_return)
			res_d.code = STATUS_BAD_RETURN;
		else
			res_d.code = STATUS_OK;
	end

	// Per-thread history of the last issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++)
				last_pc_q[i] <= '0;
			prev_act_q <= '0;
			pending_q  <= 1'b0;
		end else if (in_fire) begin
			for (int i = 0; i < THREADS; i++)
				if (act[i])
					last_pc_q[i] <= pc[i];
			prev_act_q <= act;
			pending_q  <= pick.found & brm[pick.ref_id];
		end
	end

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q  <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (!out_valid_q || out_fire)
				out_q <= res_d;
			else
				skid_q <= res_d;
		end else if (out_fire && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign active_mask   = out_q.active;
	assign chosen_thread = out_q.chosen;
	assign chosen_pc     = out_q.pc;
	assign status        = out_q.code;

`ifndef SYNTHESIS
	// The skid stage only fills behind a held result
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat with the output register empty");

	// No thread means nobody runs
	a_none_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STATUS_NONE)) |->
			(active_mask == 4'd0 && chosen_pc == 32'd0))
		else $error("idle result carries active threads");

	// The reference thread is among the active ones
	a_ref_active: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STATUS_NONE)) |-> active_mask[chosen_thread])
		else $error("reference thread not active");

	// A beat with no thread clears the branch history
	a_none_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !pick.found) |=> (prev_act_q == '0 && !pending_q))
		else $error("history kept after an idle beat");
`endif

endmodule

### sv/mprc_lane.sv
module mprc_lane (
	input  mprc_pkg::pc_t       pc,
	input  mprc_pkg::pc_t       last_pc,
	input  mprc_pkg::pc_t       ref_pc,
	input  mprc_pkg::lane_ctl_t ctl,
	output mprc_pkg::lane_t     res
);
	import mprc_pkg::*;

	logic moved_back;
	logic drop;

	// Thread left current if it branched backward last beat
	assign moved_back = ctl.pending & ctl.prev_act & (pc < last_pc);
	assign drop       = moved_back & ~ctl.ign & ctl.fun;

	assign res.cur_chk = ctl.cur & ~drop;
	assign res.elig_a  = ~ctl.ign & ctl.fun & res.cur_chk;
	assign res.elig_b  = ~ctl.ign & ctl.fun;

	// Activation against the merged reference PC
	assign res.act = res.elig_b & (pc == ref_pc);

endmodule

### sv/mprc_merge.sv
module mprc_merge (
	input  mprc_pkg::pc_t    pc [mprc_pkg::THREADS],
	input  mprc_pkg::tmask_t elig_a,
	input  mprc_pkg::tmask_t elig_b,
	output mprc_pkg::pick_t  pick
);
	import mprc_pkg::*;

	tmask_t sel;

	// Refill current once when nobody is eligible
	assign sel = (|elig_a) ? elig_a : elig_b;

	// Minimum PC, lowest index wins a tie
	always_comb begin
		pick.found  = 1'b0;
		pick.refill = ~(|elig_a);
		pick.ref_id = '0;
		pick.ref_pc = '0;
		for (int i = 0; i < THREADS; i++) begin
			if (sel[i] && (!pick.found || (pc[i] < pick.ref_pc))) begin
				pick.found  = 1'b1;
				pick.ref_id = tid_t'(i);
				pick.ref_pc = pc[i];
			end
		end
	end

endmodule

### sv/mprc_stack.sv
module mprc_stack (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mprc_pkg::stack_cmd_t   cmd,
	output mprc_pkg::tmask_t       top_cur,
	output mprc_pkg::tmask_t       top_fun,
	output mprc_pkg::stack_flags_t flags
);
	import mprc_pkg::*;

	tmask_t cur_q [STACK_DEPTH];
	tmask_t fun_q [STACK_DEPTH];
	top_t   top_q;

	logic   full;
	tmask_t fun_left;
	top_t   top_up;
	top_t   top_dn;

	assign top_cur  = cur_q[top_q];
	assign top_fun  = fun_q[top_q];
	assign full     = (top_q == top_t'(STACK_DEPTH - 1));
	assign fun_left = top_fun & ~cmd.active;
	assign top_up   = top_q + top_t'(1);
	assign top_dn   = top_q - top_t'(1);

	// Status seen by this beat
	assign flags.overflow   = cmd.found & cmd.call & full;
	assign flags.bad_return = cmd.found & ~cmd.call & cmd.ret &
	                          (fun_left == '0) & (top_q == '0);

	// Frame updates: call pushes, return retires and pops an emptied frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// bottom frame all ones, the rest empty
			for (int i = 0; i < STACK_DEPTH; i++) begin
				cur_q[i] <= (i == 0) ? TMASK_ALL : tmask_t'('0);
				fun_q[i] <= (i == 0) ? TMASK_ALL : tmask_t'('0);
			end
			top_q <= '0;
		end else if (cmd.fire) begin
			if (!cmd.found) begin
				cur_q[top_q] <= cmd.cur;
			end else if (cmd.call) begin
				cur_q[top_q] <= cmd.cur;
				if (!full) begin
					cur_q[top_up] <= TMASK_ALL;
					fun_q[top_up] <= cmd.active;
					top_q         <= top_up;
				end
			end else if (cmd.ret) begin
				if (fun_left != '0) begin
					cur_q[top_q] <= cmd.cur;
					fun_q[top_q] <= fun_left;
				end else if (top_q == '0) begin
					cur_q[0] <= TMASK_ALL;
					fun_q[0] <= TMASK_ALL;
				end else begin
					cur_q[top_q] <= '0;
					fun_q[top_q] <= '0;
					top_q        <= top_dn;
				end
			end else begin
				cur_q[top_q] <= cmd.cur;
			end
		end
	end

`ifndef SYNTHESIS
	// A successful push raises the top by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fire && cmd.found && cmd.call && !full) |=> (top_q == $past(top_up)))
		else $error("push did not raise the stack top");

	// The top never moves without a beat
	a_top_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.fire |=> $stable(top_q))
		else $error("stack top moved without a beat");

	// The bottom frame always has threads in function
	a_bottom_live: assert property (@(posedge clk) disable iff (!arst_n)
		(fun_q[0] != '0))
		else $error("bottom frame emptied");
`endif

endmodule

### tb/sv/tb_min_pc_thread_reconvergence_core.sv
`timescale 1ns / 1ps

module tb_min_pc_thread_reconvergence_core;
	import mprc_pkg::*;

	localparam int STALL_PCT  = 37;
	localparam int HOLD_LEN   = 48;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_WAIT = 4;
	localparam int MAX_SHOWN  = 10;

	typedef struct packed {
		logic [3:0][31:0] pcs;
		logic [3:0]       ign;
		logic [3:0]       brm;
		logic [3:0]       cam;
		logic [3:0]       rem;
	} sched_beat_t;

	typedef struct packed {
		logic [3:0]  act;
		logic [1:0]  tid;
		logic [31:0] pc;
		status_t     st;
	} sched_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] pc_thread_zero = '0;
	logic [31:0] pc_thread_one = '0;
	logic [31:0] pc_thread_two = '0;
	logic [31:0] pc_thread_three = '0;
	logic [3:0]  ignore_mask = '0;
	logic [3:0]  branch_mask = '0;
	logic [3:0]  call_mask = '0;
	logic [3:0]  return_mask = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  active_mask;
	logic [1:0]  chosen_thread;
	logic [31:0] chosen_pc;
	logic [1:0]  status;

	// Scheduler state mirrored by the predictor
	logic [31:0] last_pc [4];
	logic [3:0]  prev_act;
	logic        branch_pending;
	logic [3:0]  frame_cur [STACK_DEPTH];
	logic [3:0]  frame_fun [STACK_DEPTH];
	int unsigned frame_top;

	sched_result_t pending_results [$];
	int          error_count = 0;
	int          idle_cycles = 0;
	logic        tx_quiet = 1'b0;
	logic        rx_quiet = 1'b0;
	int          hold_token = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	logic [31:0] program_base = 32'h100;

	min_pc_thread_reconvergence_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pc_thread_zero (pc_thread_zero),
		.pc_thread_one  (pc_thread_one),
		.pc_thread_two  (pc_thread_two),
		.pc_thread_three(pc_thread_three),
		.ignore_mask    (ignore_mask),
		.branch_mask    (branch_mask),
		.call_mask      (call_mask),
		.return_mask    (return_mask),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.active_mask    (active_mask),
		.chosen_thread  (chosen_thread),
		.chosen_pc      (chosen_pc),
		.status         (status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic log_failure(input string msg);
		if (error_count < MAX_SHOWN)
			$display("[%0t] %s", $realtime, msg);
		error_count++;
	endtask

	// State after reset: one frame, everyone current and in-function
	task automatic clear_schedule_state();
		for (int i = 0; i < 4; i++)
			last_pc[i] = '0;
		for (int f = 0; f < STACK_DEPTH; f++) begin
			frame_cur[f] = '0;
			frame_fun[f] = '0;
		end
		frame_cur[0]   = TMASK_ALL;
		frame_fun[0]   = TMASK_ALL;
		prev_act       = '0;
		branch_pending = 1'b0;
		frame_top      = 0;
	endtask

	// One scheduling decision; updates the mirrored state
	function automatic sched_result_t schedule_next(input sched_beat_t b);
		logic [3:0]    cur;
		logic [3:0]    fun;
		logic [3:0]    act;
		int            lead;
		status_t       st;
		sched_result_t r;
		cur  = frame_cur[frame_top];
		fun  = frame_fun[frame_top];
		act  = '0;
		lead = -1;
		st   = STATUS_OK;

		// backward-branch check on the threads that just issued
		if (branch_pending)
			for (int i = 0; i < 4; i++)
				if (!b.ign[i] && prev_act[i] && fun[i] && cur[i] && b.pcs[i] < last_pc[i])
					cur[i] = 1'b0;

		// min-PC search, refilling current once
		for (int attempt = 0; attempt < 2 && lead < 0; attempt++) begin
			for (int i = 0; i < 4; i++)
				if (!b.ign[i] && fun[i] && cur[i] && (lead < 0 || b.pcs[i] < b.pcs[lead]))
					lead = i;
			if (lead < 0)
				cur = TMASK_ALL;
		end

		if (lead < 0) begin
			frame_cur[frame_top] = cur;
			prev_act             = '0;
			branch_pending       = 1'b0;
			r.act = '0;
			r.tid = '0;
			r.pc  = '0;
			r.st  = STATUS_NONE;
			return r;
		end

		for (int i = 0; i < 4; i++)
			if (!b.ign[i] && fun[i] && b.pcs[i] == b.pcs[lead]) begin
				act[i]     = 1'b1;
				last_pc[i] = b.pcs[i];
				cur[i]     = 1'b1;
			end
		frame_cur[frame_top] = cur;
		prev_act             = act;
		branch_pending       = b.brm[lead];

		// call wins over return when the reference has both
		if (b.cam[lead]) begin
			if (frame_top + 1 < STACK_DEPTH) begin
				frame_top++;
				frame_cur[frame_top] = TMASK_ALL;
				frame_fun[frame_top] = act;
			end else
				st = STATUS_OVERFLOW;
		end else if (b.rem[lead]) begin
			fun                  = fun & ~act;
			frame_fun[frame_top] = fun;
			if (fun == '0) begin
				if (frame_top == 0) begin
					st           = STATUS_BAD_RETURN;
					frame_cur[0] = TMASK_ALL;
					frame_fun[0] = TMASK_ALL;
				end else begin
					frame_cur[frame_top] = '0;
					frame_fun[frame_top] = '0;
					frame_top--;
				end
			end
		end

		r.act = act;
		r.tid = lead[1:0];
		r.pc  = b.pcs[lead];
		r.st  = st;
		return r;
	endfunction

	function automatic sched_beat_t mk_beat(input logic [31:0] p0, p1, p2, p3,
			input logic [3:0] ign, brm, cam, rem);
		sched_beat_t b;
		b.pcs = {p3, p2, p1, p0};
		b.ign = ign;
		b.brm = brm;
		b.cam = cam;
		b.rem = rem;
		return b;
	endfunction

	// Mostly converging threads near a wandering PC; a fifth is pure noise
	function automatic sched_beat_t random_beat();
		sched_beat_t b;
		if ($urandom_range(0, 4) == 0) begin
			for (int i = 0; i < 4; i++)
				b.pcs[i] = $urandom;
			b.ign = 4'($urandom);
			b.brm = 4'($urandom);
			b.cam = 4'($urandom);
			b.rem = 4'($urandom);
			return b;
		end
		if ($urandom_range(0, 7) == 0)
			program_base = program_base - 4 * $urandom_range(1, 16);
		else
			program_base = program_base + 4 * $urandom_range(0, 3);
		for (int i = 0; i < 4; i++) begin
			b.pcs[i] = $urandom_range(0, 1) ? program_base
				: program_base + 4 * $urandom_range(0, 3) - 8;
			b.ign[i] = ($urandom_range(0, 9) == 0);
			b.brm[i] = ($urandom_range(0, 2) == 0);
			b.cam[i] = ($urandom_range(0, 5) == 0);
			b.rem[i] = ($urandom_range(0, 3) == 0);
		end
		return b;
	endfunction

	// Offer one beat, hold it until taken, then record its expected result
	task automatic send_beat(input sched_beat_t b);
		// idle cycles drawn one at a time
		if (!tx_quiet)
			while ($urandom_range(0, 99) < STALL_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid        <= 1'b1;
		pc_thread_zero  <= b.pcs[0];
		pc_thread_one   <= b.pcs[1];
		pc_thread_two   <= b.pcs[2];
		pc_thread_three <= b.pcs[3];
		ignore_mask     <= b.ign;
		branch_mask     <= b.brm;
		call_mask       <= b.cam;
		return_mask     <= b.rem;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.insert(pending_results.size(), schedule_next(b));
	endtask

	task automatic test_min_pc_select();
		send_beat(mk_beat(100, 80, 60, 120, 4'h0, 4'h0, 4'h0, 4'h0));
		send_beat(mk_beat(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 4'h0, 4'h0, 4'h0, 4'h0));
		send_beat(mk_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			4'h0, 4'h0, 4'h0, 4'h0));
		send_beat(mk_beat(40, 40, 40, 8, 4'b1000, 4'h0, 4'h0, 4'h0));
	endtask

	// Nobody eligible, then current emptied by a backward branch and refilled
	task automatic test_empty_and_refill();
		send_beat(mk_beat(10, 20, 30, 40, 4'hF, 4'h0, 4'h0, 4'h0));
		send_beat(mk_beat(200, 200, 200, 200, 4'h0, 4'hF, 4'h0, 4'h0));
		send_beat(mk_beat(100, 100, 100, 100, 4'h0, 4'h0, 4'h0, 4'h0));
	endtask

	task automatic test_backward_branch();
		send_beat(mk_beat(100, 100, 200, 200, 4'h0, 4'b0001, 4'h0, 4'h0));
		send_beat(mk_beat(40, 104, 200, 200, 4'h0, 4'h0, 4'h0, 4'h0));
		send_beat(mk_beat(40, 108, 200, 200, 4'h0, 4'h0, 4'h0, 4'h0));
		send_beat(mk_beat(200, 200, 200, 200, 4'h0, 4'h0, 4'h0, 4'h0));
	endtask

	task automatic test_call_return();
		send_beat(mk_beat(300, 300, 500, 500, 4'h0, 4'h0, 4'b0001, 4'h0));
		send_beat(mk_beat(1000, 1004, 1000, 1000, 4'h0, 4'h0, 4'h0, 4'h0));
		send_beat(mk_beat(1004, 1004, 1000, 1000, 4'h0, 4'h0, 4'h0, 4'b0001));
		send_beat(mk_beat(600, 600, 600, 600, 4'h0, 4'h0, 4'hF, 4'hF));
		send_beat(mk_beat(700, 700, 700, 700, 4'h0, 4'h0, 4'h0, 4'hF));
	endtask

	task automatic test_irregular_return();
		send_beat(mk_beat(800, 800, 800, 800, 4'h0, 4'h0, 4'h0, 4'b0100));
		send_beat(mk_beat(804, 804, 804, 804, 4'h0, 4'h0, 4'h0, 4'h0));
	endtask

	// Nest until the stack is full, then unwind past the bottom frame
	task automatic test_stack_overflow();
		logic [31:0] pc;
		for (int n = 0; n < STACK_DEPTH; n++) begin
			pc = $urandom;
			send_beat(mk_beat(pc, pc, pc, pc, 4'h0, 4'h0, 4'hF, 4'h0));
		end
		for (int n = 0; n <= STACK_DEPTH; n++) begin
			pc = $urandom;
			send_beat(mk_beat(pc, pc, pc, pc, 4'h0, 4'h0, 4'h0, 4'hF));
		end
	endtask

	task automatic test_random_traffic(input int beats);
		for (int n = 0; n < beats; n++)
			send_beat(random_beat());
	endtask

	task automatic test_steady_stream(input int beats);
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		test_random_traffic(beats);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// Long result hold-off while input keeps coming, so the input side stalls
	task automatic test_output_backpressure();
		tx_quiet = 1'b1;
		hold_token++;
		test_random_traffic(30);
		tx_quiet = 1'b0;
	endtask

	// Result side: random stall, quiet stretches and long hold-offs
	always @(posedge clk) begin
		if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_LEN;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= !rx_quiet && ($urandom_range(0, 99) < STALL_PCT);
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin : result_check
		sched_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0)
				log_failure($sformatf("unexpected result act=%h tid=%0d pc=%h st=%0d",
					active_mask, chosen_thread, chosen_pc, status));
			else begin
				want = pending_results.pop_front();
				if (active_mask !== want.act)
					log_failure($sformatf("active_mask: expected %h got %h",
						want.act, active_mask));
				if (chosen_thread !== want.tid)
					log_failure($sformatf("chosen_thread: expected %0d got %0d",
						want.tid, chosen_thread));
				if (chosen_pc !== want.pc)
					log_failure($sformatf("chosen_pc: expected %h got %h", want.pc, chosen_pc));
				if (status !== want.st)
					log_failure($sformatf("status: expected %0d got %0d", want.st, status));
			end
		end
	end

	// Watchdog on cycles with no beat moving either way
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clear_schedule_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_min_pc_select();
		test_empty_and_refill();
		test_backward_branch();
		test_call_return();
		test_irregular_return();
		test_stack_overflow();
		test_random_traffic(250);
		test_steady_stream(150);
		test_output_backpressure();
		test_random_traffic(130);
		in_valid <= 1'b0;

		// drain, then wait for any stray beat
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_results.size() != 0)
			log_failure($sformatf("%0d results never arrived", pending_results.size()));

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### min_pc_thread_reconvergence_core.f
sv/mprc_pkg.sv
sv/mprc_lane.sv
sv/mprc_merge.sv
sv/mprc_stack.sv
sv/min_pc_thread_reconvergence_core.sv
tb/sv/tb_min_pc_thread_reconvergence_core.sv
